// File: hdl/lc3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3 execute package
// Shared constants, codes, command and status structures and helpers.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int MEMORY_WORDS = 65536;
    localparam int MEM_AW = $clog2(MEMORY_WORDS);

    localparam logic [15:0] USER_START_RST = 16'h3000;
    localparam logic [15:0] USER_MAX_RST = 16'hFDFF;

    typedef logic [3:0] status_t;
    localparam status_t ST_OK = 4'd0;
    localparam status_t ST_HALT = 4'd1;
    localparam status_t ST_PAD = 4'd2;
    localparam status_t ST_OPC = 4'd3;
    localparam status_t ST_BRC = 4'd4;
    localparam status_t ST_LOW = 4'd5;
    localparam status_t ST_HIGH = 4'd6;
    localparam status_t ST_TRAP = 4'd7;
    localparam status_t ST_UNSUP = 4'd8;
    localparam status_t ST_STOP = 4'd9;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_EXEC = 2'd2;

    localparam logic [3:0] OP_BR = 4'h0;
    localparam logic [3:0] OP_ADD = 4'h1;
    localparam logic [3:0] OP_LD = 4'h2;
    localparam logic [3:0] OP_ST = 4'h3;
    localparam logic [3:0] OP_JSR = 4'h4;
    localparam logic [3:0] OP_AND = 4'h5;
    localparam logic [3:0] OP_LDR = 4'h6;
    localparam logic [3:0] OP_STR = 4'h7;
    localparam logic [3:0] OP_NOT = 4'h9;
    localparam logic [3:0] OP_LDI = 4'hA;
    localparam logic [3:0] OP_STI = 4'hB;
    localparam logic [3:0] OP_JMP = 4'hC;
    localparam logic [3:0] OP_LEA = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [7:0] TV_GETC = 8'h20;
    localparam logic [7:0] TV_OUT = 8'h21;
    localparam logic [7:0] TV_PUTS = 8'h22;
    localparam logic [7:0] TV_IN = 8'h23;
    localparam logic [7:0] TV_PUTSP = 8'h24;
    localparam logic [7:0] TV_HALT = 8'h25;
    localparam logic [7:0] TV_DUMP = 8'h27;

    typedef struct packed {
        logic clr;
        logic disp;
        logic fetch;
        logic exec;
        logic ind;
        logic load;
        logic done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic run;
        logic pc_fault;
        logic need_ind;
        logic need_load;
    } dp_stat_t;

    function automatic status_t range_chk(input logic [15:0] a, input logic [15:0] lo,
                                          input logic [15:0] hi);
        status_t s;
        if (a < lo)
        begin
            s = ST_LOW;
        end
        else if (a > hi)
        begin
            s = ST_HIGH;
        end
        else
        begin
            s = ST_OK;
        end
        return s;
    endfunction

    function automatic logic [2:0] nzp(input logic [15:0] v);
        logic [2:0] f;
        if (v[15])
        begin
            f = 3'b100;
        end
        else if (v == 16'h0000)
        begin
            f = 3'b010;
        end
        else
        begin
            f = 3'b001;
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// File: hdl/lc3_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3 execute controller
// One-hot sequencer for memory clearing, dispatch, fetch, execute and result.
// ----------------------------------------------------------------------------
module lc3_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lc3_pkg::dp_stat_t stat,
    output lc3_pkg::ctrl_cmd_t     cmd_o,
    output logic                   busy
);
    import lc3_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_FETCH = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_IND   = 8'b0010_0000,
        S_LOAD  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = stat.run ? S_FETCH : S_DONE;
            end
            S_FETCH:
            begin
                state_next = stat.pc_fault ? S_DONE : S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.need_ind)
                begin
                    state_next = S_IND;
                end
                else if (stat.need_load)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_IND:
            begin
                state_next = stat.need_load ? S_LOAD : S_DONE;
            end
            S_LOAD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cmd_o.clr   = (state_reg == S_CLEAR);
    assign cmd_o.disp  = (state_reg == S_DISP);
    assign cmd_o.fetch = (state_reg == S_FETCH);
    assign cmd_o.exec  = (state_reg == S_EXEC);
    assign cmd_o.ind   = (state_reg == S_IND);
    assign cmd_o.load  = (state_reg == S_LOAD);
    assign cmd_o.done  = (state_reg == S_DONE);
    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/lc3_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3 execute datapath
// Register file, PC, flags, configuration, word memory and instruction logic.
// ----------------------------------------------------------------------------
module lc3_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lc3_pkg::ctrl_cmd_t cmd_i,
    input  wire logic               accept,
    input  wire logic [1:0]         cmd,
    input  wire logic [15:0]        load_addr,
    input  wire logic [15:0]        load_data,
    input  wire logic [7:0]         char_in,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data,
    output lc3_pkg::dp_stat_t       stat,
    output logic [3:0]              status,
    output logic [15:0]             pc_now,
    output logic [6:0]              char_out,
    output logic                    char_valid
);
    import lc3_pkg::*;

    logic [15:0] mem [MEMORY_WORDS];
    logic [15:0] rdata_reg;
    logic        mem_re;
    logic        mem_we;
    logic [MEM_AW-1:0] mem_raddr;
    logic [MEM_AW-1:0] mem_waddr;
    logic [15:0] mem_wdata;

    logic [15:0] rf_reg [8];
    logic [15:0] pc_reg;
    logic [2:0]  flags_reg;
    logic        stopped_reg;
    status_t     status_reg;
    logic [6:0]  cout_reg;
    logic        cval_reg;
    logic [15:0] ustart_reg;
    logic [15:0] umax_reg;
    logic [MEM_AW-1:0] clr_addr_reg;
    logic [1:0]  cmd_reg;
    logic [15:0] laddr_reg;
    logic [15:0] ldata_reg;
    logic [7:0]  ch_reg;
    logic [15:0] ir_reg;

    logic [15:0] ins;
    logic [3:0]  op;
    logic [2:0]  dr;
    logic [2:0]  sr;
    logic [15:0] pc_off9;
    logic [15:0] ea;
    logic [15:0] v2;
    status_t     pc_st;
    status_t     ex_st;
    status_t     ea_st;
    logic        ex_rf_we;
    logic [2:0]  ex_rf_idx;
    logic [15:0] ex_rf_data;
    logic        ex_flags_we;
    logic        ex_pc_we;
    logic [15:0] ex_pc;
    logic        ex_store;
    logic        ex_need_ind;
    logic        ex_need_load;
    logic        ex_cval;
    status_t     ind_st;
    logic        ind_ldi;

    assign ins = rdata_reg;
    assign op = ins[15:12];
    assign dr = ins[11:9];
    assign sr = ins[8:6];
    assign pc_off9 = pc_reg + {{7{ins[8]}}, ins[8:0]};
    assign ea = (op == OP_LDR || op == OP_STR)
              ? rf_reg[sr] + {{10{ins[5]}}, ins[5:0]} : pc_off9;
    assign ea_st = range_chk(ea, ustart_reg, umax_reg);
    assign pc_st = range_chk(pc_reg, ustart_reg, umax_reg);

    always_comb
    begin
        ex_st = ST_OK;
        ex_rf_we = 1'b0;
        ex_rf_idx = dr;
        ex_rf_data = 16'h0000;
        ex_flags_we = 1'b0;
        ex_pc_we = 1'b0;
        ex_pc = pc_reg;
        ex_store = 1'b0;
        ex_need_ind = 1'b0;
        ex_need_load = 1'b0;
        ex_cval = 1'b0;
        v2 = ins[5] ? {{11{ins[4]}}, ins[4:0]} : rf_reg[ins[2:0]];
        case (op)
            OP_ADD, OP_AND:
            begin
                if (!ins[5] && ins[4:3] != 2'b00)
                begin
                    ex_st = ST_PAD;
                end
                else
                begin
                    ex_rf_we = 1'b1;
                    ex_flags_we = 1'b1;
                    ex_rf_data = (op == OP_ADD) ? rf_reg[sr] + v2 : rf_reg[sr] & v2;
                end
            end
            OP_NOT:
            begin
                if (ins[5:0] != 6'h3F)
                begin
                    ex_st = ST_PAD;
                end
                else
                begin
                    ex_rf_we = 1'b1;
                    ex_flags_we = 1'b1;
                    ex_rf_data = ~rf_reg[sr];
                end
            end
            OP_BR:
            begin
                if (ins == 16'h0000)
                begin
                    ex_st = ST_OK;
                end
                else if (dr == 3'b000)
                begin
                    ex_st = ST_BRC;
                end
                else if ((dr & flags_reg) != 3'b000)
                begin
                    ex_pc_we = 1'b1;
                    ex_pc = pc_off9;
                end
            end
            OP_JMP:
            begin
                if (dr != 3'b000 || ins[5:0] != 6'h00)
                begin
                    ex_st = ST_PAD;
                end
                else
                begin
                    ex_pc_we = 1'b1;
                    ex_pc = rf_reg[sr];
                end
            end
            OP_JSR:
            begin
                if (!ins[11] && ins[10:9] != 2'b00)
                begin
                    ex_st = ST_PAD;
                end
                else
                begin
                    ex_pc_we = 1'b1;
                    ex_pc = ins[11] ? pc_reg + {{5{ins[10]}}, ins[10:0]} : rf_reg[sr];
                    ex_rf_we = 1'b1;
                    ex_rf_idx = 3'd7;
                    ex_rf_data = pc_reg;
                end
            end
            OP_LD, OP_LDR, OP_LDI:
            begin
                ex_st = ea_st;
                if (ea_st == ST_OK)
                begin
                    ex_need_ind = (op == OP_LDI);
                    ex_need_load = (op != OP_LDI);
                end
            end
            OP_ST, OP_STR, OP_STI:
            begin
                ex_st = ea_st;
                if (ea_st == ST_OK)
                begin
                    ex_need_ind = (op == OP_STI);
                    ex_store = (op != OP_STI);
                end
            end
            OP_LEA:
            begin
                ex_rf_we = 1'b1;
                ex_flags_we = 1'b1;
                ex_rf_data = pc_off9;
            end
            OP_TRAP:
            begin
                if (ins[11:8] != 4'h0)
                begin
                    ex_st = ST_PAD;
                end
                else
                begin
                    case (ins[7:0])
                        TV_GETC, TV_IN:
                        begin
                            ex_rf_we = 1'b1;
                            ex_rf_idx = 3'd0;
                            ex_rf_data = {8'h00, ch_reg};
                        end
                        TV_OUT:
                        begin
                            ex_cval = 1'b1;
                        end
                        TV_HALT:
                        begin
                            ex_st = ST_HALT;
                        end
                        TV_PUTS, TV_PUTSP, TV_DUMP:
                        begin
                            ex_st = ST_UNSUP;
                        end
                        default:
                        begin
                            ex_st = ST_TRAP;
                        end
                    endcase
                end
            end
            default:
            begin
                ex_st = ST_OPC;
            end
        endcase
    end

    assign ind_st = range_chk(rdata_reg, ustart_reg, umax_reg);
    assign ind_ldi = (ir_reg[15:12] == OP_LDI);

    assign stat.clr_last = &clr_addr_reg;
    assign stat.run = (cmd_reg == CMD_EXEC) && !stopped_reg;
    assign stat.pc_fault = (pc_st != ST_OK);
    assign stat.need_ind = ex_need_ind;
    assign stat.need_load = cmd_i.ind ? (ind_ldi && ind_st == ST_OK) : ex_need_load;

    always_comb
    begin
        mem_re = 1'b0;
        mem_raddr = pc_reg[MEM_AW-1:0];
        mem_we = 1'b0;
        mem_waddr = clr_addr_reg;
        mem_wdata = 16'h0000;
        if (cmd_i.clr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd_i.disp && cmd_reg == CMD_LOAD)
        begin
            mem_we = 1'b1;
            mem_waddr = laddr_reg[MEM_AW-1:0];
            mem_wdata = ldata_reg;
        end
        else if (cmd_i.fetch)
        begin
            mem_re = 1'b1;
        end
        else if (cmd_i.exec)
        begin
            mem_re = 1'b1;
            mem_raddr = ea[MEM_AW-1:0];
            mem_we = ex_store;
            mem_waddr = ea[MEM_AW-1:0];
            mem_wdata = rf_reg[dr];
        end
        else if (cmd_i.ind)
        begin
            mem_re = 1'b1;
            mem_raddr = rdata_reg[MEM_AW-1:0];
            mem_we = !ind_ldi && (ind_st == ST_OK);
            mem_waddr = rdata_reg[MEM_AW-1:0];
            mem_wdata = rf_reg[ir_reg[11:9]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            laddr_reg <= load_addr;
            ldata_reg <= load_data;
            ch_reg <= char_in;
        end
        if (cmd_i.exec)
        begin
            ir_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                rf_reg[i] <= 16'h0000;
            end
            pc_reg <= 16'h0000;
            flags_reg <= 3'b000;
            stopped_reg <= 1'b0;
            status_reg <= ST_OK;
            cout_reg <= 7'h00;
            cval_reg <= 1'b0;
            ustart_reg <= USER_START_RST;
            umax_reg <= USER_MAX_RST;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index)
                begin
                    umax_reg <= cfg_data;
                end
                else
                begin
                    ustart_reg <= cfg_data;
                end
            end
            if (cmd_i.clr)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd_i.disp)
            begin
                cout_reg <= 7'h00;
                cval_reg <= 1'b0;
                status_reg <= (cmd_reg != CMD_RESTART && cmd_reg != CMD_LOAD && stopped_reg)
                            ? ST_STOP : ST_OK;
                if (cmd_reg == CMD_RESTART)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        rf_reg[i] <= 16'h0000;
                    end
                    flags_reg <= 3'b000;
                    pc_reg <= ustart_reg;
                    stopped_reg <= 1'b0;
                end
            end
            if (cmd_i.fetch)
            begin
                if (pc_st != ST_OK)
                begin
                    status_reg <= pc_st;
                    stopped_reg <= 1'b1;
                end
                else
                begin
                    pc_reg <= pc_reg + 16'd1;
                end
            end
            if (cmd_i.exec)
            begin
                if (ex_st != ST_OK)
                begin
                    status_reg <= ex_st;
                    stopped_reg <= 1'b1;
                end
                if (ex_rf_we)
                begin
                    rf_reg[ex_rf_idx] <= ex_rf_data;
                end
                if (ex_flags_we)
                begin
                    flags_reg <= nzp(ex_rf_data);
                end
                if (ex_pc_we)
                begin
                    pc_reg <= ex_pc;
                end
                cval_reg <= ex_cval;
                cout_reg <= ex_cval ? rf_reg[0][6:0] : 7'h00;
            end
            if (cmd_i.ind && ind_st != ST_OK)
            begin
                status_reg <= ind_st;
                stopped_reg <= 1'b1;
            end
            if (cmd_i.load)
            begin
                rf_reg[ir_reg[11:9]] <= rdata_reg;
                flags_reg <= nzp(rdata_reg);
            end
        end
    end

    assign status = status_reg;
    assign pc_now = pc_reg;
    assign char_out = cout_reg;
    assign char_valid = cval_reg;

endmodule
`default_nettype wire

// File: hdl/lc3_instruction_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LC-3 instruction execute core
// Restart, memory load and single-instruction execution with strict checks.
// ----------------------------------------------------------------------------
// Restart, load, idle and stopped execute items go from dispatch straight to
// the result. A running execute steps through fetch, execute, a pointer read
// for LDI/STI and a data read for loads; a fetch fault ends after fetch.
// A new item is taken in the cycle after the result strobe; results cannot stall.
// After reset the memory is cleared one word a cycle, all 65536 words, with busy
// high; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module lc3_instruction_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] load_addr,
    input  wire logic [15:0] load_data,
    input  wire logic [7:0]  char_in,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [3:0]       status,
    output logic [15:0]      pc_now,
    output logic [6:0]       char_out,
    output logic             char_valid
);
    import lc3_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  dst;
    logic      accept;

    assign accept = start && !busy;

    lc3_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dst),
        .cmd_o (ctl),
        .busy  (busy)
    );

    lc3_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_i      (ctl),
        .accept     (accept),
        .cmd        (cmd),
        .load_addr  (load_addr),
        .load_data  (load_data),
        .char_in    (char_in),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .stat       (dst),
        .status     (status),
        .pc_now     (pc_now),
        .char_out   (char_out),
        .char_valid (char_valid)
    );

    assign done = ctl.done;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && !done)
        else $error("item accepted without going busy");
    a_char_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done && char_valid) |-> (status == ST_OK))
        else $error("character output with a fault status");
`endif

endmodule
`default_nettype wire
